// ===== design/tcp_pkg.sv =====
// shared constants, types and tables of the texture coordinate projection unit
package tcp_pkg;

   // number of vectoring steps of the angle unit (8 to 32)
   localparam int CORDIC_STEPS = 16;

   // fixed-point widths
   localparam int LOC_W   = 33;  // local vector, exact difference of two Q16.16 values
   localparam int DIV_BITS = 49; // magnitude of local value scaled by 2^16
   localparam int REM_W   = 32;  // remainder, always below the divisor magnitude
   localparam int CRD_W   = 52;  // cordic x and y, scaled local values plus gain
   localparam int ANG_W   = 27;  // angle accumulator in turns, Q3.24
   localparam int TAB_W   = 25;

   // latency of both arithmetic units: input stage, one stage per quotient bit, output stage
   localparam int PIPE_LAT   = DIV_BITS + 2;
   localparam int CORDIC_PAD = PIPE_LAT - CORDIC_STEPS - 2;

   // constants
   localparam logic signed [31:0] Q_ONE  = 32'sd65536;
   localparam logic signed [31:0] Q_HALF = 32'sd32768;
   localparam logic signed [ANG_W-1:0] TURN_HALF = 27'sd8388608;

   // register indexes of the configuration port
   localparam logic [2:0] REG_MODE     = 3'd0;
   localparam logic [2:0] REG_AXIS     = 3'd1;
   localparam logic [2:0] REG_CENTER_X = 3'd2;
   localparam logic [2:0] REG_CENTER_Y = 3'd3;
   localparam logic [2:0] REG_CENTER_Z = 3'd4;
   localparam logic [2:0] REG_SIZE_X   = 3'd5;
   localparam logic [2:0] REG_SIZE_Y   = 3'd6;
   localparam logic [2:0] REG_SIZE_Z   = 3'd7;

   // projection modes
   localparam logic [1:0] MODE_NONE   = 2'd0;
   localparam logic [1:0] MODE_PLANAR = 2'd1;
   localparam logic [1:0] MODE_CYL    = 2'd2;
   localparam logic [1:0] MODE_CUBIC  = 2'd3;

   // axis codes
   localparam logic [1:0] AXIS_X = 2'd0;
   localparam logic [1:0] AXIS_Y = 2'd1;
   localparam logic [1:0] AXIS_Z = 2'd2;

   // atan(2^-i) in turns, Q1.24
   localparam logic [TAB_W-1:0] TURN_TABLE [0:31] = '{
      25'd2097152, 25'd1238021, 25'd654136, 25'd332050,
      25'd166669,  25'd83416,   25'd41718,  25'd20860,
      25'd10430,   25'd5215,    25'd2608,   25'd1304,
      25'd652,     25'd326,     25'd163,    25'd81,
      25'd41,      25'd20,      25'd10,     25'd5,
      25'd3,       25'd1,       25'd1,      25'd0,
      25'd0,       25'd0,       25'd0,      25'd0,
      25'd0,       25'd0,       25'd0,      25'd0
   };

   // one word for an arithmetic unit
   typedef struct packed {
      logic                    valid;
      logic signed [LOC_W-1:0] num;
      logic signed [31:0]      den;
   } div_word_type;

   typedef struct packed {
      logic                    valid;
      logic                    sel;
      logic signed [LOC_W-1:0] ang_y;
      logic signed [LOC_W-1:0] ang_x;
   } ang_word_type;

endpackage

// ===== design/tcp_divider.sv =====
// pipelined signed divider giving a saturated planar texture term
module tcp_divider (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    enable,
   input  tcp_pkg::div_word_type   in_word,
   output logic                    out_valid,
   output logic signed [31:0]      out_term
);

   localparam int NB = tcp_pkg::DIV_BITS;

   logic                          vld_ff [0:NB];
   logic                          neg_ff [0:NB];
   logic [NB-1:0]                 sh_ff  [0:NB];
   logic [tcp_pkg::REM_W-1:0]     rem_ff [0:NB];
   logic [31:0]                   den_ff [0:NB];
   logic                          out_valid_ff;
   logic signed [31:0]            out_term_ff;

   logic [tcp_pkg::LOC_W-1:0]     num_mag;
   logic [31:0]                   den_mag;
   logic signed [NB+1:0]          q_signed;
   logic signed [NB+1:0]          sum;
   logic signed [31:0]            out_term_in;

   // magnitudes and sign of the quotient
   always_comb begin
      num_mag = in_word.num[tcp_pkg::LOC_W-1] ? (~in_word.num + 1'b1) : in_word.num;
      den_mag = in_word.den[31] ? (~in_word.den + 1'b1) : in_word.den;
   end

   // input stage
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (enable) begin
         vld_ff[0] <= in_word.valid;
      end
      if (enable) begin
         neg_ff[0] <= in_word.num[tcp_pkg::LOC_W-1] ^ in_word.den[31];
         sh_ff[0]  <= {num_mag, 16'b0};
         rem_ff[0] <= '0;
         den_ff[0] <= den_mag;
      end
   end

   // one quotient bit per stage, restoring
   for (genvar k = 1; k <= NB; k++) begin : g_step
      logic [tcp_pkg::REM_W:0] trial;
      logic                    ge;
      always_comb begin
         trial = {rem_ff[k-1], sh_ff[k-1][NB-1]};
         ge    = (trial >= {1'b0, den_ff[k-1]});
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (enable) begin
            vld_ff[k] <= vld_ff[k-1];
         end
         if (enable) begin
            neg_ff[k] <= neg_ff[k-1];
            den_ff[k] <= den_ff[k-1];
            sh_ff[k]  <= {sh_ff[k-1][NB-2:0], ge};
            rem_ff[k] <= ge ? tcp_pkg::REM_W'(trial - {1'b0, den_ff[k-1]})
                            : trial[tcp_pkg::REM_W-1:0];
         end
      end
   end

   // sign, offset by one half and saturate
   always_comb begin
      q_signed = neg_ff[NB] ? -$signed({2'b00, sh_ff[NB]}) : $signed({2'b00, sh_ff[NB]});
      sum      = q_signed + (NB+2)'(tcp_pkg::Q_HALF);
      if (sum > (NB+2)'(32'sh7FFFFFFF)) begin
         out_term_in = 32'sh7FFFFFFF;
      end else if (sum < -(NB+2)'(64'sh80000000)) begin
         out_term_in = 32'sh80000000;
      end else begin
         out_term_in = sum[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (enable) begin
         out_valid_ff <= vld_ff[NB];
      end
      if (enable) begin
         out_term_ff <= out_term_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_term  = out_term_ff;

endmodule

// ===== design/tcp_cordic.sv =====
// pipelined vectoring cordic giving the cylindrical u term in turns
module tcp_cordic (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    enable,
   input  tcp_pkg::ang_word_type   in_word,
   output logic                    out_valid,
   output logic                    out_sel,
   output logic signed [31:0]      out_term
);

   localparam int NS = tcp_pkg::CORDIC_STEPS;
   localparam int NP = tcp_pkg::CORDIC_PAD;
   localparam int W  = tcp_pkg::CRD_W;
   localparam int AW = tcp_pkg::ANG_W;

   logic                   vld_ff  [0:NS];
   logic                   sel_ff  [0:NS];
   logic                   zero_ff [0:NS];
   logic signed [W-1:0]    x_ff    [0:NS];
   logic signed [W-1:0]    y_ff    [0:NS];
   logic signed [AW-1:0]   z_ff    [0:NS];

   logic                   rvld_ff [0:NP];
   logic                   rsel_ff [0:NP];
   logic signed [31:0]     res_ff  [0:NP];

   logic signed [W-1:0]    x_sc;
   logic signed [W-1:0]    y_sc;
   logic signed [AW-1:0]   zr;
   logic signed [31:0]     res_in;

   // scale by 2^16
   always_comb begin
      x_sc = W'(in_word.ang_x) <<< 16;
      y_sc = W'(in_word.ang_y) <<< 16;
   end

   // left half plane folds over with a half turn start
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (enable) begin
         vld_ff[0] <= in_word.valid;
      end
      if (enable) begin
         sel_ff[0]  <= in_word.sel;
         zero_ff[0] <= (in_word.ang_x == '0) && (in_word.ang_y == '0);
         if (in_word.ang_x[tcp_pkg::LOC_W-1]) begin
            x_ff[0] <= -x_sc;
            y_ff[0] <= -y_sc;
            z_ff[0] <= in_word.ang_y[tcp_pkg::LOC_W-1] ? -tcp_pkg::TURN_HALF
                                                       : tcp_pkg::TURN_HALF;
         end else begin
            x_ff[0] <= x_sc;
            y_ff[0] <= y_sc;
            z_ff[0] <= '0;
         end
      end
   end

   // one vectoring step per stage
   for (genvar k = 1; k <= NS; k++) begin : g_step
      logic signed [W-1:0]  xs;
      logic signed [W-1:0]  ys;
      logic signed [AW-1:0] t;
      always_comb begin
         xs = x_ff[k-1] >>> (k-1);
         ys = y_ff[k-1] >>> (k-1);
         t  = AW'(tcp_pkg::TURN_TABLE[k-1]);
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (enable) begin
            vld_ff[k] <= vld_ff[k-1];
         end
         if (enable) begin
            sel_ff[k]  <= sel_ff[k-1];
            zero_ff[k] <= zero_ff[k-1];
            if (!y_ff[k-1][W-1]) begin
               x_ff[k] <= x_ff[k-1] + ys;
               y_ff[k] <= y_ff[k-1] - xs;
               z_ff[k] <= z_ff[k-1] + t;
            end else begin
               x_ff[k] <= x_ff[k-1] - ys;
               y_ff[k] <= y_ff[k-1] + xs;
               z_ff[k] <= z_ff[k-1] - t;
            end
         end
      end
   end

   // round turns to q16.16 and add one half
   always_comb begin
      zr = (z_ff[NS] + AW'(128)) >>> 8;
      if (zero_ff[NS]) begin
         res_in = tcp_pkg::Q_HALF;
      end else begin
         res_in = tcp_pkg::Q_HALF + 32'(zr);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rvld_ff[0] <= 1'b0;
      end else if (enable) begin
         rvld_ff[0] <= vld_ff[NS];
      end
      if (enable) begin
         rsel_ff[0] <= sel_ff[NS];
         res_ff[0]  <= res_in;
      end
   end

   // delay to match the divider latency
   for (genvar p = 1; p <= NP; p++) begin : g_pad
      always_ff @(posedge clock) begin
         if (reset) begin
            rvld_ff[p] <= 1'b0;
         end else if (enable) begin
            rvld_ff[p] <= rvld_ff[p-1];
         end
         if (enable) begin
            rsel_ff[p] <= rsel_ff[p-1];
            res_ff[p]  <= res_ff[p-1];
         end
      end
   end

   assign out_valid = rvld_ff[NP];
   assign out_sel   = rsel_ff[NP];
   assign out_term  = res_ff[NP];

endmodule

// ===== design/texture_coordinate_projection_unit.sv =====
// top level of the texture coordinate projection unit
// Usage:
//   Slave stream req_*: one vertex word per handshake, position and triangle normal,
//   six signed Q16.16 values. Master stream rsp_*: one word of texture u and v per
//   vertex, signed Q16.16, in the order the vertices came in.
//   Register port csr_*: index and data, always ready; write only while the unit is
//   empty of vertices.
// Pipeline: from acceptance to the result word on rsp_tdata a vertex passes one operand
//   stage, 51 stages in the arithmetic units (49 quotient bits of the restoring
//   dividers set this, the cordic is padded to match) and the output register.
// Throughput: one vertex per cycle, in steady flow.
// Stall: the whole pipeline holds while a result word waits and rsp_tready is low;
//   req_tready then drops, and nothing is lost or repeated. When the output word is
//   taken or absent the pipeline advances and a new vertex can enter the same cycle.
// Reset: synchronous, active high; clears all valid bits, mode and axis to zero,
//   centre to zero and sizes to 1.0.
module texture_coordinate_projection_unit (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [191:0]  req_tdata,   // pos_x, pos_y, pos_z, normal_x, normal_y, normal_z
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [63:0]   rsp_tdata,   // tex_u, tex_v
   input  logic          csr_valid,
   output logic          csr_ready,
   input  logic [2:0]    csr_index,
   input  logic [31:0]   csr_data
);

   localparam int LW = tcp_pkg::LOC_W;

   logic [1:0]          mode_ff;
   logic [2:0]          axis_ff;
   logic signed [31:0]  cx_ff, cy_ff, cz_ff;
   logic signed [31:0]  sx_ff, sy_ff, sz_ff;

   logic                   en;
   logic signed [31:0]     px, py, pz, nx, ny, nz;
   logic signed [LW-1:0]   lx, ly, lz;
   logic signed [31:0]     sxe, sye, sze;
   logic [31:0]            ax, ay, az;
   logic [1:0]             axis;
   logic                   cyl;

   tcp_pkg::div_word_type  du_in, dv_in, du_ff, dv_ff;
   tcp_pkg::ang_word_type  an_in, an_ff;

   logic                   du_valid, dv_valid, an_valid, an_sel;
   logic signed [31:0]     du_term, dv_term, an_term;

   logic                   rsp_tvalid_ff;
   logic [63:0]            rsp_tdata_ff;

   // configuration writes
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= tcp_pkg::MODE_NONE;
         axis_ff <= '0;
         cx_ff   <= '0;
         cy_ff   <= '0;
         cz_ff   <= '0;
         sx_ff   <= tcp_pkg::Q_ONE;
         sy_ff   <= tcp_pkg::Q_ONE;
         sz_ff   <= tcp_pkg::Q_ONE;
      end else if (csr_valid) begin
         unique case (csr_index)
            tcp_pkg::REG_MODE:     mode_ff <= csr_data[1:0];
            tcp_pkg::REG_AXIS:     axis_ff <= csr_data[2:0];
            tcp_pkg::REG_CENTER_X: cx_ff   <= csr_data;
            tcp_pkg::REG_CENTER_Y: cy_ff   <= csr_data;
            tcp_pkg::REG_CENTER_Z: cz_ff   <= csr_data;
            tcp_pkg::REG_SIZE_X:   sx_ff   <= csr_data;
            tcp_pkg::REG_SIZE_Y:   sy_ff   <= csr_data;
            tcp_pkg::REG_SIZE_Z:   sz_ff   <= csr_data;
         endcase
      end
   end

   // pipeline advances when the output word is free or taken
   assign en         = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = en;

   // local vector, effective sizes and normal magnitudes
   always_comb begin
      px  = req_tdata[31:0];
      py  = req_tdata[63:32];
      pz  = req_tdata[95:64];
      nx  = req_tdata[127:96];
      ny  = req_tdata[159:128];
      nz  = req_tdata[191:160];
      lx  = LW'(px) - LW'(cx_ff);
      ly  = LW'(py) - LW'(cy_ff);
      lz  = LW'(pz) - LW'(cz_ff);
      sxe = (sx_ff == '0) ? tcp_pkg::Q_ONE : sx_ff;
      sye = (sy_ff == '0) ? tcp_pkg::Q_ONE : sy_ff;
      sze = (sz_ff == '0) ? tcp_pkg::Q_ONE : sz_ff;
      ax  = nx[31] ? (~nx + 1'b1) : nx;
      ay  = ny[31] ? (~ny + 1'b1) : ny;
      az  = nz[31] ? (~nz + 1'b1) : nz;
   end

   // axis selection
   always_comb begin
      axis = tcp_pkg::AXIS_Y;
      cyl  = (mode_ff == tcp_pkg::MODE_CYL);
      if (mode_ff == tcp_pkg::MODE_PLANAR || mode_ff == tcp_pkg::MODE_CYL) begin
         priority if (axis_ff[0]) begin
            axis = tcp_pkg::AXIS_X;
         end else if (axis_ff[1]) begin
            axis = tcp_pkg::AXIS_Y;
         end else if (axis_ff[2]) begin
            axis = tcp_pkg::AXIS_Z;
         end else begin
            axis = tcp_pkg::AXIS_Y;
         end
      end else if (mode_ff == tcp_pkg::MODE_CUBIC) begin
         priority if (ax == '0 && ay == '0 && az == '0) begin
            axis = tcp_pkg::AXIS_Y;
         end else if (ax >= ay && ax >= az) begin
            axis = tcp_pkg::AXIS_X;
         end else if (ay >= az) begin
            axis = tcp_pkg::AXIS_Y;
         end else begin
            axis = tcp_pkg::AXIS_Z;
         end
      end
   end

   // operand routing to the units
   always_comb begin
      du_in.valid = req_tvalid;
      dv_in.valid = req_tvalid;
      an_in.valid = req_tvalid;
      an_in.sel   = cyl;
      if (cyl) begin
         unique case (axis)
            tcp_pkg::AXIS_X: begin
               an_in.ang_y = lz;  an_in.ang_x = ly;
               dv_in.num   = lx;  dv_in.den   = sxe;
            end
            tcp_pkg::AXIS_Z: begin
               an_in.ang_y = lx;  an_in.ang_x = ly;
               dv_in.num   = lz;  dv_in.den   = sze;
            end
            default: begin
               an_in.ang_y = lx;  an_in.ang_x = lz;
               dv_in.num   = ly;  dv_in.den   = sye;
            end
         endcase
         du_in.num = lx;
         du_in.den = sxe;
      end else begin
         unique case (axis)
            tcp_pkg::AXIS_X: begin
               du_in.num = lz;  du_in.den = sze;
               dv_in.num = ly;  dv_in.den = sye;
            end
            tcp_pkg::AXIS_Z: begin
               du_in.num = lx;  du_in.den = sxe;
               dv_in.num = ly;  dv_in.den = sye;
            end
            default: begin
               du_in.num = lx;  du_in.den = sxe;
               dv_in.num = lz;  dv_in.den = sze;
            end
         endcase
         an_in.ang_y = lx;
         an_in.ang_x = lz;
      end
   end

   // operand stage
   always_ff @(posedge clock) begin
      if (reset) begin
         du_ff.valid <= 1'b0;
         dv_ff.valid <= 1'b0;
         an_ff.valid <= 1'b0;
      end else if (en) begin
         du_ff.valid <= du_in.valid;
         dv_ff.valid <= dv_in.valid;
         an_ff.valid <= an_in.valid;
      end
      if (en) begin
         du_ff.num   <= du_in.num;
         du_ff.den   <= du_in.den;
         dv_ff.num   <= dv_in.num;
         dv_ff.den   <= dv_in.den;
         an_ff.sel   <= an_in.sel;
         an_ff.ang_y <= an_in.ang_y;
         an_ff.ang_x <= an_in.ang_x;
      end
   end

   tcp_divider u_div_u (
      .clock     (clock),
      .reset     (reset),
      .enable    (en),
      .in_word   (du_ff),
      .out_valid (du_valid),
      .out_term  (du_term)
   );

   tcp_divider u_div_v (
      .clock     (clock),
      .reset     (reset),
      .enable    (en),
      .in_word   (dv_ff),
      .out_valid (dv_valid),
      .out_term  (dv_term)
   );

   tcp_cordic u_cordic (
      .clock     (clock),
      .reset     (reset),
      .enable    (en),
      .in_word   (an_ff),
      .out_valid (an_valid),
      .out_sel   (an_sel),
      .out_term  (an_term)
   );

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (en) begin
         rsp_tvalid_ff <= du_valid && dv_valid && an_valid;
      end
      if (en) begin
         rsp_tdata_ff <= {dv_term, (an_sel ? an_term : du_term)};
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

endmodule
